// ===== src/priority_schedule_wait_times_core_macros.svh =====
// ----------------------------------------------------------------------------
// Priority scheduler assertion macros
// Shorthand for clocked assertions that are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_CORE_MACROS_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSCHED_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSCHED_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/psched_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority scheduler package
// Shared sizes, payload structs and the back-end state type.
// ----------------------------------------------------------------------------
package psched_pkg;

	localparam int MAX_PROCESSES = 64;
	localparam int IDX_W = $clog2(MAX_PROCESSES);
	localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
	localparam int TIME_W = 22;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0]  process_tag;
		logic [15:0] burst_time;
		logic [7:0]  priority_req;
		logic        last_process;
	} req_item_t;

	typedef struct packed {
		logic [7:0]        out_tag;
		logic [7:0]        out_priority;
		logic [15:0]       out_burst;
		logic [TIME_W-1:0] wait_time;
		logic [TIME_W-1:0] turnaround_time;
		logic              last_result;
	} rsp_item_t;

	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] burst;
		logic [7:0]  tag;
	} entry_t;

	typedef struct packed {
		entry_t           entry;
		logic [CNT_W-1:0] count;
		logic             store;
		logic             last_proc;
	} q_item_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_CUR,
		ST_CMP,
		ST_FIN,
		ST_EMIT_RD,
		ST_DATA,
		ST_HOLD
	} back_state_t;

endpackage

// ===== src/psched_front.sv =====
// ----------------------------------------------------------------------------
// Priority scheduler front end
// Accepts processes, numbers them within the batch and marks overflow items.
// ----------------------------------------------------------------------------
module psched_front import psched_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      push_valid,
	input  logic      push_ready,
	output q_item_t   push_item
);

	logic [CNT_W-1:0] count_q;
	logic             store;

	assign store = count_q < CNT_W'(MAX_PROCESSES);
	assign req_ready = push_ready;
	assign push_valid = req_valid;

	always_comb begin
		push_item.entry.prio = req.priority_req;
		push_item.entry.burst = req.burst_time;
		push_item.entry.tag = req.process_tag;
		push_item.count = count_q;
		push_item.store = store;
		push_item.last_proc = req.last_process;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (req_valid && push_ready) begin
			if (req.last_process) begin
				count_q <= '0;
			end else if (store) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/psched_fifo.sv =====
// ----------------------------------------------------------------------------
// Priority scheduler queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module psched_fifo import psched_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  q_item_t push_item,
	output logic    pop_valid,
	input  logic    pop,
	output q_item_t pop_item
);

	q_item_t           slots [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = fill_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid = fill_q != '0;
	assign pop_item = slots[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== src/psched_back.sv =====
// ----------------------------------------------------------------------------
// Priority scheduler back end
// Stores the batch, runs the exchange sort over one memory port and emits
// results with running wait times.
// ----------------------------------------------------------------------------
module psched_back import psched_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  q_item_t   q_item,
	output logic      q_pop,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	back_state_t       state_q;
	back_state_t       state_d;
	entry_t            proc_mem [MAX_PROCESSES];
	entry_t            rd_q;
	entry_t            cur_q;
	logic [CNT_W-1:0]  n_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  k_q;
	logic [TIME_W-1:0] wait_q;
	rsp_item_t         rsp_q;
	logic              rsp_valid_q;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	entry_t            wdata;

	logic [CNT_W-1:0]  n_next;
	logic              j_last;
	logic              i_more;
	logic              k_last;
	logic              swap;
	logic              rsp_take;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] sat;

	assign n_next = q_item.store ? q_item.count + CNT_W'(1) : q_item.count;
	assign j_last = (CNT_W'(j_q) + CNT_W'(1)) == n_q;
	assign i_more = (CNT_W'(i_q) + CNT_W'(2)) < n_q;
	assign k_last = (CNT_W'(k_q) + CNT_W'(1)) == n_q;
	assign swap = cur_q.prio > rd_q.prio;
	assign rsp_take = rsp_valid_q && rsp_ready;
	assign sum = {1'b0, wait_q} + (TIME_W + 1)'(rd_q.burst);
	assign sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (q_valid && q_item.last_proc) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = (n_q > CNT_W'(1)) ? ST_CUR : ST_DATA;
			end
			ST_CUR: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (j_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = i_more ? ST_CUR : ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				state_d = ST_DATA;
			end
			ST_DATA: begin
				state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (rsp_take) begin
					state_d = k_last ? ST_LOAD : ST_DATA;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		rd_en = 1'b0;
		rd_addr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = cur_q;
		unique case (state_q)
			ST_LOAD: begin
				q_pop = q_valid;
				we = q_valid && q_item.store;
				waddr = q_item.count[IDX_W-1:0];
				wdata = q_item.entry;
			end
			ST_START: begin
				rd_en = 1'b1;
			end
			ST_CUR: begin
				rd_en = 1'b1;
				rd_addr = i_q + IDX_W'(1);
			end
			ST_CMP: begin
				we = swap;
				waddr = j_q;
				rd_en = !j_last;
				rd_addr = j_q + IDX_W'(1);
			end
			ST_FIN: begin
				we = 1'b1;
				waddr = i_q;
				rd_en = i_more;
				rd_addr = i_q + IDX_W'(1);
			end
			ST_EMIT_RD: begin
				rd_en = 1'b1;
				rd_addr = k_q;
			end
			ST_DATA: begin
			end
			ST_HOLD: begin
				rd_en = rsp_take && !k_last;
				rd_addr = k_q + IDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			proc_mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= proc_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_CUR: begin
				cur_q <= rd_q;
			end
			ST_CMP: begin
				if (swap) begin
					cur_q <= rd_q;
				end
			end
			ST_DATA: begin
				rsp_q.out_tag <= rd_q.tag;
				rsp_q.out_priority <= rd_q.prio;
				rsp_q.out_burst <= rd_q.burst;
				rsp_q.wait_time <= wait_q;
				rsp_q.turnaround_time <= sat;
				rsp_q.last_result <= k_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			wait_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (q_valid && q_item.last_proc) begin
						n_q <= n_next;
						i_q <= '0;
						k_q <= '0;
						wait_q <= '0;
					end
				end
				ST_CUR: begin
					j_q <= i_q + IDX_W'(1);
				end
				ST_CMP: begin
					j_q <= j_q + IDX_W'(1);
				end
				ST_FIN: begin
					i_q <= i_q + IDX_W'(1);
				end
				ST_DATA: begin
					wait_q <= sat;
					rsp_valid_q <= 1'b1;
				end
				ST_HOLD: begin
					if (rsp_take) begin
						rsp_valid_q <= 1'b0;
						k_q <= k_q + IDX_W'(1);
						if (k_last) begin
							n_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/priority_schedule_wait_times_core.sv =====
// ----------------------------------------------------------------------------
// Priority schedule wait times core
// Non-preemptive priority scheduling of a batch of processes.
//
// Channel  Dir  Handshake              Transaction
// req      in   req_valid/req_ready    one process; last_process ends a batch
// rsp      out  rsp_valid/rsp_ready    one scheduled process with wait times
//
// Processes are taken one per cycle while the four-entry queue has room.
// After the last process of a batch of n > 1, the sort runs over the single
// memory port. A batch of one process skips the sort.
// Each result is formed in ST_DATA and held in ST_HOLD until it is taken.
// Reset needs no clearing pass; the table holds no valid bits.
// A stalled rsp holds the back end, and req stalls once the queue fills.
// ----------------------------------------------------------------------------
`include "priority_schedule_wait_times_core_macros.svh"

module priority_schedule_wait_times_core import psched_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	logic    push_valid;
	logic    push_ready;
	q_item_t push_item;
	logic    q_valid;
	logic    q_pop;
	q_item_t q_item;
	logic    ta_ok;
	logic    rsp_fire;

	psched_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	psched_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item)
	);

	psched_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	assign ta_ok = rsp.turnaround_time >= rsp.wait_time;
	assign rsp_fire = rsp_valid && rsp_ready;

	`PSCHED_ASSERT_SAME(a_pop_nonempty, q_pop, q_valid, "Back end popped an empty queue.")
	`PSCHED_ASSERT_SAME(a_turnaround_ge_wait, rsp_valid, ta_ok, "Turnaround below wait.")
	`PSCHED_ASSERT_NEXT(a_rsp_gap, rsp_fire, !rsp_valid, "Valid held after a transaction.")

endmodule

// ===== bench/priority_schedule_wait_times_core_tb.sv =====
// ----------------------------------------------------------------------------
// Priority schedule wait times core testbench
// Sends batches of processes into the scheduler and checks every scheduled
// result against a local model of the exchange sort and the running wait
// and turnaround sums. Both channels idle at random except near the end.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times_core_tb import psched_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          TARGET_ITEMS = 130;
	localparam int          STALL_LIMIT  = 20000;
	localparam int          DRAIN_CYCLES = 200;
	localparam int          MAX_PRINTS   = 60;
	localparam int unsigned TIME_CAP     = (1 << TIME_W) - 1;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req_data  = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp_data;

	req_item_t pending_q[$];
	rsp_item_t schedule_q[$];
	entry_t    proc_table[MAX_PROCESSES];
	int        n_loaded     = 0;
	int        n_errors     = 0;
	int        total_items  = 0;
	int        issued_items = 0;
	int        send_gap     = 0;
	int        stall_gap    = 0;
	int        quiet_cycles = 0;

	priority_schedule_wait_times_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report(input string msg);
		n_errors++;
		if (n_errors <= MAX_PRINTS) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	// Loads one process and, at the end of a batch, sorts the table and
	// queues the schedule in the order the block must emit it.
	task automatic schedule_process(input req_item_t item);
		entry_t      swap_tmp;
		rsp_item_t   res;
		int unsigned elapsed;
		int unsigned done;
		if (n_loaded < MAX_PROCESSES) begin
			proc_table[n_loaded].prio  = item.priority_req;
			proc_table[n_loaded].burst = item.burst_time;
			proc_table[n_loaded].tag   = item.process_tag;
			n_loaded++;
		end
		if (!item.last_process) begin
			return;
		end
		for (int i = 0; i < n_loaded - 1; i++) begin
			for (int j = i + 1; j < n_loaded; j++) begin
				if (proc_table[i].prio > proc_table[j].prio) begin
					swap_tmp      = proc_table[i];
					proc_table[i] = proc_table[j];
					proc_table[j] = swap_tmp;
				end
			end
		end
		elapsed = 0;
		for (int k = 0; k < n_loaded; k++) begin
			done = elapsed + proc_table[k].burst;
			if (done > TIME_CAP) begin
				done = TIME_CAP;
			end
			res.out_tag         = proc_table[k].tag;
			res.out_priority    = proc_table[k].prio;
			res.out_burst       = proc_table[k].burst;
			res.wait_time       = elapsed[TIME_W-1:0];
			res.turnaround_time = done[TIME_W-1:0];
			res.last_result     = (k == n_loaded - 1);
			schedule_q.push_back(res);
			elapsed = done;
		end
		n_loaded = 0;
	endtask

	task automatic check_result(input rsp_item_t got);
		rsp_item_t want;
		if (schedule_q.size() == 0) begin
			report($sformatf("result with nothing expected, tag %0d", got.out_tag));
			return;
		end
		want = schedule_q.pop_front();
		if (got.out_tag !== want.out_tag) begin
			report($sformatf("out_tag %0d, expected %0d", got.out_tag, want.out_tag));
		end
		if (got.out_priority !== want.out_priority) begin
			report($sformatf("out_priority %0d, expected %0d", got.out_priority,
				want.out_priority));
		end
		if (got.out_burst !== want.out_burst) begin
			report($sformatf("out_burst %0d, expected %0d", got.out_burst, want.out_burst));
		end
		if (got.wait_time !== want.wait_time) begin
			report($sformatf("wait_time %0d, expected %0d", got.wait_time, want.wait_time));
		end
		if (got.turnaround_time !== want.turnaround_time) begin
			report($sformatf("turnaround_time %0d, expected %0d", got.turnaround_time,
				want.turnaround_time));
		end
		if (got.last_result !== want.last_result) begin
			report($sformatf("last_result %0b, expected %0b", got.last_result,
				want.last_result));
		end
	endtask

	task automatic add_process(input logic [7:0] tag, input logic [15:0] burst,
		input logic [7:0] prio, input logic last);
		req_item_t item;
		item.process_tag  = tag;
		item.burst_time   = burst;
		item.priority_req = prio;
		item.last_process = last;
		pending_q.push_back(item);
	endtask

	task automatic add_random_batch(input int size, input bit narrow);
		logic [15:0] burst;
		logic [7:0]  prio;
		for (int k = 0; k < size; k++) begin
			burst = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
				: 16'($urandom_range(0, 65535));
			prio  = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
			add_process(8'($urandom_range(0, 255)), burst, prio, k == size - 1);
		end
	endtask

	// Driver: the next process goes out once the current one is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				schedule_process(req_data);
			end
			if (!(req_valid && !req_ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					req_valid <= 1'b1;
					req_data  <= pending_q.pop_front();
					issued_items++;
					if (issued_items < total_items * 3 / 4 && $urandom_range(0, 7) == 0) begin
						send_gap = $urandom_range(1, 10);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transaction and stalls the result side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				check_result(rsp_data);
			end
			if (stall_gap > 0) begin
				stall_gap--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (issued_items < total_items * 3 / 4 && $urandom_range(0, 7) == 0) begin
					stall_gap = $urandom_range(1, 10);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL priority_schedule_wait_times_core");
				$finish;
			end
		end
	end

	initial begin
		// Single-process batches at the field extremes.
		add_process(8'd255, 16'd65535, 8'd255, 1'b1);
		add_process(8'd0, 16'd0, 8'd0, 1'b1);
		// Priorities arriving in descending order.
		add_process(8'd10, 16'd100, 8'd200, 1'b0);
		add_process(8'd11, 16'd0, 8'd150, 1'b0);
		add_process(8'd12, 16'd65535, 8'd100, 1'b0);
		add_process(8'd13, 16'd7, 8'd50, 1'b0);
		add_process(8'd14, 16'd1, 8'd0, 1'b1);
		// Equal priorities among others; the exchange sort keeps their arrival order here.
		add_process(8'd20, 16'd5, 8'd2, 1'b0);
		add_process(8'd21, 16'd6, 8'd2, 1'b0);
		add_process(8'd22, 16'd7, 8'd1, 1'b0);
		add_process(8'd23, 16'd8, 8'd3, 1'b0);
		add_process(8'd24, 16'd9, 8'd1, 1'b1);
		// All priorities equal, arrival order kept.
		add_process(8'd30, 16'd43690, 8'd85, 1'b0);
		add_process(8'd31, 16'd21845, 8'd85, 1'b0);
		add_process(8'd32, 16'd0, 8'd85, 1'b1);
		// Full table with maximum bursts, then two discarded processes, the
		// second of which still ends the batch.
		for (int k = 0; k < MAX_PROCESSES + 2; k++) begin
			add_process(k[7:0], 16'd65535, 8'($urandom_range(0, 255)),
				k == MAX_PROCESSES + 1);
		end
		while (pending_q.size() < TARGET_ITEMS) begin
			add_random_batch(($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
				: $urandom_range(1, 6), 1'($urandom_range(0, 1)));
		end
		total_items = pending_q.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() > 0 || req_valid || schedule_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (schedule_q.size() > 0) begin
			report($sformatf("%0d results never arrived", schedule_q.size()));
		end
		if (n_errors == 0) begin
			$display("PASS priority_schedule_wait_times_core");
		end else begin
			$display("FAIL priority_schedule_wait_times_core");
		end
		$finish;
	end

endmodule
